// ===== src/jtm_pkg.sv =====
// ---------------------------------------------------------------------------
// jtm_pkg: shared types and constants for the joystick to mouse block
// Fixed-point constants, register indexes and the sequencer state type.
// ---------------------------------------------------------------------------
package jtm_pkg;
  localparam int ADC_BITS_DEF  = 10;
  localparam int TIME_BITS_DEF = 16;
  localparam int Q            = 14;
  localparam logic [14:0] ONE_Q14    = 15'd16384;
  localparam logic [13:0] OFFSET_Q14 = 14'd4915;
  localparam logic [15:0] SCALE_PTR  = 16'd32768;
  localparam logic [15:0] SCALE_SCR  = 16'd1638;

  localparam logic [2:0] REG_X_MIN = 3'd0;
  localparam logic [2:0] REG_X_DLO = 3'd1;
  localparam logic [2:0] REG_X_DHI = 3'd2;
  localparam logic [2:0] REG_X_MAX = 3'd3;
  localparam logic [2:0] REG_Y_MIN = 3'd4;
  localparam logic [2:0] REG_Y_DLO = 3'd5;
  localparam logic [2:0] REG_Y_DHI = 3'd6;
  localparam logic [2:0] REG_Y_MAX = 3'd7;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DIVX, ST_DIVY, ST_CHECK, ST_SQRT, ST_K, ST_VX, ST_VY,
    ST_RX, ST_RY, ST_DONE
  } state_t;
endpackage

// ===== src/jtm_serdiv.sv =====
// ---------------------------------------------------------------------------
// jtm_serdiv: restoring divider, one quotient bit per cycle
// Computes floor(num * 2^14 / den) for num < den.
// ---------------------------------------------------------------------------
module jtm_serdiv import jtm_pkg::*; #(
  parameter int W = ADC_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] num,
  input  logic [W-1:0] den,
  output logic         busy,
  output logic [Q-1:0] quo
);
  logic [W:0]   rem;
  logic [W-1:0] dv;
  logic [3:0]   cnt;
  logic [W+1:0] sh;
  logic [W+1:0] diff;

  assign sh   = {rem, 1'b0};
  assign diff = sh - {2'b00, dv};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= 4'(Q - 1);
      rem  <= {1'b0, num};
      dv   <= den;
      quo  <= '0;
    end else if (busy) begin
      // one restoring step: shift, trial subtract, keep if non-negative
      if (!diff[W+1]) begin
        rem <= diff[W:0];
        quo <= {quo[Q-2:0], 1'b1};
      end else begin
        rem <= sh[W:0];
        quo <= {quo[Q-2:0], 1'b0};
      end
      if (cnt == 4'd0) busy <= 1'b0;
      cnt <= cnt - 4'd1;
    end
  end
endmodule

// ===== src/jtm_sqrt.sv =====
// ---------------------------------------------------------------------------
// jtm_sqrt: bit-serial integer square root
// Two radicand bits per cycle, one root bit per cycle, 30-bit radicand.
// ---------------------------------------------------------------------------
module jtm_sqrt import jtm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [29:0] rad,
  output logic        busy,
  output logic [15:0] root
);
  logic [29:0] v;
  logic [17:0] rem;
  logic [3:0]  cnt;
  logic [17:0] trial;
  logic [17:0] rsh;

  assign rsh   = {rem[15:0], v[29:28]};
  assign trial = {root, 2'b01};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= 4'd14;
      v    <= rad;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      v <= {v[27:0], 2'b00};
      if (rsh >= trial) begin
        rem  <= rsh - trial;
        root <= {root[14:0], 1'b1};
      end else begin
        rem  <= rsh;
        root <= {root[14:0], 1'b0};
      end
      if (cnt == 4'd0) busy <= 1'b0;
      cnt <= cnt - 4'd1;
    end
  end
endmodule

// ===== src/jtm_sermul.sv =====
// ---------------------------------------------------------------------------
// jtm_sermul: shift-and-add multiplier, one multiplier bit per cycle
// Unsigned a * b with a 16-bit multiplier operand.
// ---------------------------------------------------------------------------
module jtm_sermul import jtm_pkg::*; #(
  parameter int AW = 32
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [AW-1:0]   a,
  input  logic [15:0]     b,
  output logic            busy,
  output logic [AW+15:0]  prod
);
  logic [AW+15:0] acc_a;
  logic [15:0]    bb;
  logic [4:0]     cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      cnt   <= 5'd15;
      acc_a <= {16'd0, a};
      bb    <= b;
      prod  <= '0;
    end else if (busy) begin
      if (bb[0]) prod <= prod + acc_a;
      acc_a <= {acc_a[AW+14:0], 1'b0};
      bb    <= {1'b0, bb[15:1]};
      if (cnt == 5'd0) busy <= 1'b0;
      cnt <= cnt - 5'd1;
    end
  end
endmodule

// ===== src/joystick_to_mouse_motion.sv =====
// ---------------------------------------------------------------------------
// joystick_to_mouse_motion: analogue stick to pointer or wheel motion
// Dead zone, normalise, length-scaled gain, time-weighted rate, report.
// ---------------------------------------------------------------------------
// One word in flight: a new word is taken only once the sequencer is back in
//   idle (a centred word, which never reports, returns there after the check).
// Each word runs through the serial divider (once per axis), the serial square
//   root and five serial multiplies; a result still waiting on the output holds
//   the final step. Reset (rst, synchronous): registers to defaults, last times
//   and re-arm cleared, sequencer idle.
module joystick_to_mouse_motion import jtm_pkg::*; #(
  parameter int ADC_BITS  = ADC_BITS_DEF,
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  // tdata: x_sample, y_sample, now_ms (lowest bit up)
  input  logic [((2*ADC_BITS+TIME_BITS+7)/8)*8-1:0] s_tdata,
  // tuser: mode
  input  logic                s_tuser,
  output logic                m_tvalid,
  input  logic                m_tready,
  // tdata: move_x, move_y, wheel_h, wheel_v (lowest bit up)
  output logic [31:0]         m_tdata,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [ADC_BITS-1:0] cfg_data
);
  localparam int AW = ADC_BITS;
  localparam int TW = TIME_BITS;

  state_t state, state_next;

  logic [AW-1:0] cfg_r [8];
  logic [AW-1:0] xs, ys;
  logic [TW-1:0] now;
  logic          scroll;
  logic [TW-1:0] last_x, last_y;
  logic          rearm;

  logic [14:0] ax, ay;
  logic        nx, ny;
  logic [15:0] m;
  logic [31:0] k;
  logic [31:0] vx, vy;
  logic [TW-1:0] elx, ely;
  logic [63:0] rx, ry;
  logic [6:0]  ix, iy;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_r[REG_X_MIN] <= AW'(200);
      cfg_r[REG_X_DLO] <= AW'(520);
      cfg_r[REG_X_DHI] <= AW'(562);
      cfg_r[REG_X_MAX] <= AW'(885);
      cfg_r[REG_Y_MIN] <= AW'(120);
      cfg_r[REG_Y_DLO] <= AW'(476);
      cfg_r[REG_Y_DHI] <= AW'(522);
      cfg_r[REG_Y_MAX] <= AW'(880);
    end else if (cfg_we) begin
      cfg_r[cfg_index] <= cfg_data;
    end
  end

  // dead-zone classification for one axis: active, sign, full, numerator, denominator
  function automatic logic [2*AW+2:0] classify(input logic [AW-1:0] s, lo, dlo, dhi, hi);
    logic [AW-1:0] num, den;
    logic neg, act, full;
    begin
      num = '0; den = '0; neg = 1'b0; act = 1'b0; full = 1'b0;
      if (s < dlo) begin
        act = 1'b1; neg = 1'b1; num = dlo - s;
        den = (lo < dlo) ? dlo - lo : '0;
      end else if (s > dhi) begin
        act = 1'b1; num = s - dhi;
        den = (hi > dhi) ? hi - dhi : '0;
      end
      full = act && (den == '0 || num >= den);
      classify = {act, neg, full, num, den};
    end
  endfunction

  logic [2*AW+2:0] cx, cy;
  assign cx = classify(xs, cfg_r[REG_X_MIN], cfg_r[REG_X_DLO], cfg_r[REG_X_DHI],
                       cfg_r[REG_X_MAX]);
  assign cy = classify(ys, cfg_r[REG_Y_MIN], cfg_r[REG_Y_DLO], cfg_r[REG_Y_DHI],
                       cfg_r[REG_Y_MAX]);

  // shared serial divider
  logic          div_start, div_busy;
  logic [AW-1:0] div_num, div_den;
  logic [Q-1:0]  div_q;
  jtm_serdiv #(.W(AW)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num), .den(div_den),
    .busy(div_busy), .quo(div_q)
  );

  logic        sq_start, sq_busy;
  logic [29:0] sq_rad;
  logic [15:0] sq_root;
  jtm_sqrt u_sqrt (
    .clk(clk), .rst(rst), .start(sq_start), .rad(sq_rad), .busy(sq_busy), .root(sq_root)
  );

  // shared serial multiplier
  logic        mul_start, mul_busy;
  logic [47:0] mul_a;
  logic [15:0] mul_b;
  logic [63:0] mul_p;
  jtm_sermul #(.AW(48)) u_mul (
    .clk(clk), .rst(rst), .start(mul_start), .a(mul_a), .b(mul_b),
    .busy(mul_busy), .prod(mul_p)
  );

  logic        phase;  // set while the current state is held, after its unit was started
  logic        unit_busy;
  logic [16:0] mo;
  logic [15:0] scale_t;
  logic        out_free;  // output register empty or being taken this cycle
  logic        report;

  // take a new word whenever idle; a waiting result only holds the last step
  assign s_tready = (state == ST_IDLE);
  assign unit_busy = div_busy | sq_busy | mul_busy;
  assign mo = {1'b0, m} + 17'(OFFSET_Q14);
  assign out_free = !m_tvalid || m_tready;
  assign report = (rx > 64'h1000_0000) || (ry > 64'h1000_0000);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (s_tvalid && s_tready) state_next = ST_DIVX;
      ST_DIVX:  if (phase && !unit_busy) state_next = ST_DIVY;
      ST_DIVY:  if (phase && !unit_busy) state_next = ST_CHECK;
      ST_CHECK: state_next = (ax == '0 && ay == '0) ? ST_IDLE : ST_SQRT;
      ST_SQRT:  if (phase && !unit_busy) state_next = ST_K;
      ST_K:     if (phase && !unit_busy) state_next = ST_VX;
      ST_VX:    if (phase && !unit_busy) state_next = ST_VY;
      ST_VY:    if (phase && !unit_busy) state_next = ST_RX;
      ST_RX:    if (phase && !unit_busy) state_next = ST_RY;
      ST_RY:    if (phase && !unit_busy) state_next = ST_DONE;
      ST_DONE:  if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // unit start strobes and operands
  always_comb begin
    div_start = 1'b0; sq_start = 1'b0; mul_start = 1'b0;
    div_num = cx[2*AW-1:AW]; div_den = cx[AW-1:0];
    sq_rad = 30'({15'd0, ax} * {15'd0, ax} + {15'd0, ay} * {15'd0, ay});
    mul_a = '0; mul_b = '0;
    case (state)
      ST_DIVX: div_start = !phase;
      ST_DIVY: begin
        div_start = !phase; div_num = cy[2*AW-1:AW]; div_den = cy[AW-1:0];
      end
      ST_SQRT: sq_start = !phase;
      ST_K:    begin mul_start = !phase; mul_a = 48'(mo); mul_b = mo[15:0]; end
      ST_VX:   begin mul_start = !phase; mul_a = 48'(k); mul_b = {1'b0, ax}; end
      ST_VY:   begin mul_start = !phase; mul_a = 48'(k); mul_b = {1'b0, ay}; end
      ST_RX:   begin mul_start = !phase; mul_a = 48'(vx) * 48'(elx); mul_b = scale_t; end
      ST_RY:   begin mul_start = !phase; mul_a = 48'(vy) * 48'(ely); mul_b = scale_t; end
      default: ;
    endcase
  end

  assign scale_t = scroll ? SCALE_SCR : SCALE_PTR;

  function automatic logic [6:0] sat(input logic [63:0] r);
    sat = (r[63:28] > 36'd127) ? 7'd127 : r[34:28];
  endfunction
  assign ix = sat(rx);
  assign iy = sat(ry);

  function automatic logic [7:0] sgn(input logic [6:0] v, input logic neg);
    sgn = neg ? -{1'b0, v} : {1'b0, v};
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE; phase <= 1'b0; m_tvalid <= 1'b0;
      last_x <= '0; last_y <= '0; rearm <= 1'b0;
    end else begin
      state <= state_next;
      phase <= (state_next == state) && (state != ST_IDLE) ? 1'b1 : 1'b0;
      if ((state == ST_DONE) && out_free && report) m_tvalid <= 1'b1;
      else if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      case (state)
        ST_IDLE: if (s_tvalid && s_tready) begin
          // hold the accepted word
          xs <= s_tdata[AW-1:0];
          ys <= s_tdata[2*AW-1:AW];
          now <= s_tdata[2*AW+TW-1:2*AW];
          scroll <= s_tuser;
        end
        ST_DIVX: if (phase && !unit_busy) begin
          nx <= cx[2*AW+1];
          ax <= !cx[2*AW+2] ? '0 : cx[2*AW] ? ONE_Q14 : {1'b0, div_q};
        end
        ST_DIVY: if (phase && !unit_busy) begin
          ny <= cy[2*AW+1];
          ay <= !cy[2*AW+2] ? '0 : cy[2*AW] ? ONE_Q14 : {1'b0, div_q};
        end
        ST_CHECK: begin
          if (ax == '0 && ay == '0) rearm <= 1'b1;
          else begin
            // first deflection after centring restarts both clocks
            if (rearm) begin
              rearm <= 1'b0; last_x <= now; last_y <= now;
              elx <= '0; ely <= '0;
            end else begin
              elx <= now - last_x; ely <= now - last_y;
            end
          end
        end
        ST_SQRT: if (phase && !unit_busy) m <= sq_root;
        ST_K:    if (phase && !unit_busy) k <= 32'(mul_p >> Q);
        ST_VX:   if (phase && !unit_busy) vx <= 32'(mul_p >> Q);
        ST_VY:   if (phase && !unit_busy) vy <= 32'(mul_p >> Q);
        ST_RX:   if (phase && !unit_busy) rx <= mul_p;
        ST_RY:   if (phase && !unit_busy) ry <= mul_p;
        ST_DONE: begin
          // hold here until the output register is free
          if (out_free && report) begin
            if (scroll)
              m_tdata <= {sgn(iy, !ny), sgn(ix, nx), 16'd0};
            else
              m_tdata <= {16'd0, sgn(iy, ny), sgn(ix, nx)};
            if (ix != '0) last_x <= now;
            if (iy != '0) last_y <= now;
          end
        end
        default: ;
      endcase
    end
  end
endmodule

// ===== src/jtm_checker.sv =====
// ---------------------------------------------------------------------------
// jtm_checker: port-level checks on the joystick to mouse block
// Watches the handshakes and the shape of result words.
// ---------------------------------------------------------------------------
module jtm_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata
);
  // one word in flight: no new word taken right after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready) else $error("two words in flight");
  // a result holds until taken
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("result dropped");
  // pointer and wheel fields are never both active
  a_mode_excl: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[15:0] == 16'd0 || m_tdata[31:16] == 16'd0))
    else $error("pointer and wheel both set");
  // every field stays within -127..127
  a_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[7:0] != 8'h80 && m_tdata[15:8] != 8'h80 &&
                  m_tdata[23:16] != 8'h80 && m_tdata[31:24] != 8'h80))
    else $error("field out of range");
endmodule

bind joystick_to_mouse_motion jtm_checker u_jtm_checker (
  .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
  .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);

// ===== test/joystick_to_mouse_motion_tb.sv =====
// ---------------------------------------------------------------------------
// joystick_to_mouse_motion_tb: self-checking bench for the stick-to-mouse block
// Streams ADC pairs with timestamps and modes through the block. A predictor
// in the bench forecasts each report. Results are compared field by field.
// The dead-zone registers are reprogrammed between phases.
// ---------------------------------------------------------------------------
module joystick_to_mouse_motion_tb;
  import jtm_pkg::*;

  localparam int DW = ((2*10+16+7)/8)*8;

  typedef struct packed {
    logic       mode;
    logic [15:0] now_ms;
    logic [9:0] y_sample;
    logic [9:0] x_sample;
  } stick_word_t;

  typedef struct packed {
    logic signed [7:0] wheel_v;
    logic signed [7:0] wheel_h;
    logic signed [7:0] move_y;
    logic signed [7:0] move_x;
  } motion_word_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [DW-1:0]     s_tdata = '0;
  logic              s_tuser = 1'b0;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [31:0]       m_tdata;
  logic              cfg_we = 1'b0;
  logic [2:0]        cfg_index = REG_X_MIN;
  logic [9:0]        cfg_data = '0;

  joystick_to_mouse_motion u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state: a private copy of the registers, last times and re-arm
  logic [9:0]   dz_reg [8];
  logic [15:0]  seen_x, seen_y;
  logic         centred;

  stick_word_t  pending_words[$];
  motion_word_t expected_motion[$];
  int           mismatches = 0;
  int           cycles = 0;
  bit           calm = 1'b0;     // no idling in the final stretch
  int           src_gap = 0, snk_gap = 0;

  // Map one sample through its dead zone to a Q2.14 deflection
  function automatic int deflection(logic [9:0] s, logic [9:0] lo, logic [9:0] dlo,
                                    logic [9:0] dhi, logic [9:0] hi);
    longint num, den, q;
    bit neg;
    if (s < dlo) begin
      num = dlo - s; den = (lo < dlo) ? longint'(dlo - lo) : 0; neg = 1;
    end else if (s > dhi) begin
      num = s - dhi; den = (hi > dhi) ? longint'(hi - dhi) : 0; neg = 0;
    end else begin
      return 0;
    end
    q = (den == 0 || num >= den) ? 16384 : (num * 16384) / den;
    return neg ? -int'(q) : int'(q);
  endfunction

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b; r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic int clip_rate(longint unsigned r, bit neg);
    longint unsigned q;
    int i;
    q = r >> 28;
    i = (q > 127) ? 127 : int'(q);
    return neg ? -i : i;
  endfunction

  // Forecast the report for one stick word, advancing predictor state
  task automatic predict_motion(stick_word_t w);
    int dx, dy, ix, iy;
    longint unsigned ax, ay, m, k, sc, rx, ry;
    logic [15:0] elx, ely;
    motion_word_t r;
    dx = deflection(w.x_sample, dz_reg[REG_X_MIN], dz_reg[REG_X_DLO],
                    dz_reg[REG_X_DHI], dz_reg[REG_X_MAX]);
    dy = deflection(w.y_sample, dz_reg[REG_Y_MIN], dz_reg[REG_Y_DLO],
                    dz_reg[REG_Y_DHI], dz_reg[REG_Y_MAX]);
    if (dx == 0 && dy == 0) begin
      centred = 1'b1;
      return;
    end
    if (centred) begin
      centred = 1'b0; seen_x = w.now_ms; seen_y = w.now_ms;
    end
    elx = w.now_ms - seen_x;
    ely = w.now_ms - seen_y;
    ax = (dx < 0) ? -dx : dx;
    ay = (dy < 0) ? -dy : dy;
    m  = root_floor(ax*ax + ay*ay);
    k  = ((m + 4915) * (m + 4915)) >> 14;
    ax = (ax * k) >> 14;
    ay = (ay * k) >> 14;
    sc = w.mode ? 1638 : 32768;
    rx = ax * elx * sc;
    ry = ay * ely * sc;
    if (rx <= (64'd1 << 28) && ry <= (64'd1 << 28)) return;
    ix = clip_rate(rx, dx < 0);
    iy = clip_rate(ry, dy < 0);
    r = '0;
    if (w.mode) begin
      r.wheel_h = ix[7:0]; r.wheel_v = 8'(-iy);
    end else begin
      r.move_x = ix[7:0]; r.move_y = iy[7:0];
    end
    if (ix != 0) seen_x = w.now_ms;
    if (iy != 0) seen_y = w.now_ms;
    expected_motion.push_back(r);
  endtask

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d want %0d at cycle %0d", what, got, want, cycles);
    mismatches++;
  endtask

  // Source side: offer the next queued word, idling in bursts
  always @(posedge clk) begin
    stick_word_t nxt;
    cycles <= cycles + 1;
    if (!rst) begin
      if (s_tvalid && s_tready) predict_motion(stick_word_t'({s_tuser, s_tdata[35:0]}));
      if (s_tvalid && !s_tready) begin
        // hold the word
      end else if (src_gap > 0) begin
        src_gap <= src_gap - 1;
        s_tvalid <= 1'b0;
      end else if (pending_words.size() > 0) begin
        if (!calm && $urandom_range(0, 5) == 0) begin
          src_gap <= $urandom_range(1, 4) - 1;
          s_tvalid <= 1'b0;
        end else begin
          nxt = pending_words.pop_front();
          s_tdata  <= DW'(nxt[35:0]);
          s_tuser  <= nxt.mode;
          s_tvalid <= 1'b1;
        end
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Sink side: random stall bursts, check every accepted result word
  always @(posedge clk) begin
    motion_word_t got, want;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got = m_tdata;
        if (expected_motion.size() == 0) begin
          report_mismatch("unexpected word", got, 0);
        end else begin
          want = expected_motion.pop_front();
          if (got.move_x  !== want.move_x)  report_mismatch("move_x",  got.move_x,  want.move_x);
          if (got.move_y  !== want.move_y)  report_mismatch("move_y",  got.move_y,  want.move_y);
          if (got.wheel_h !== want.wheel_h) report_mismatch("wheel_h", got.wheel_h, want.wheel_h);
          if (got.wheel_v !== want.wheel_v) report_mismatch("wheel_v", got.wheel_v, want.wheel_v);
        end
      end
      if (snk_gap > 0) begin
        snk_gap  <= snk_gap - 1;
        m_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        snk_gap  <= $urandom_range(1, 4) - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Timeout: ends the run as mismatches once the cycle limit is passed
  always @(posedge clk) begin
    if (cycles > 1000000) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [9:0] val);
    @(posedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    dz_reg[idx] = val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Wait until the queue drains and no result is owed, then let the block settle
  task automatic drain;
    while (pending_words.size() > 0 || s_tvalid || expected_motion.size() > 0)
      @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  function automatic stick_word_t make_word(int x, int y, int t, bit md);
    stick_word_t w;
    w.x_sample = 10'(x); w.y_sample = 10'(y); w.now_ms = 16'(t); w.mode = md;
    return w;
  endfunction

  // Mostly a centre/deflect gesture with growing time, plus some noise
  task automatic queue_random(int count, inout int t);
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 9))
        0: pending_words.push_back(make_word($urandom_range(0, 1023),
             $urandom_range(0, 1023), $urandom_range(0, 65535), 1'($urandom_range(0, 1))));
        1: pending_words.push_back(make_word(541, 499, t, 1'($urandom_range(0, 1))));
        default: begin
          t = (t + $urandom_range(0, 300)) & 16'hffff;
          if ($urandom_range(0, 15) == 0) t = (t + $urandom_range(0, 65535)) & 16'hffff;
          pending_words.push_back(make_word($urandom_range(0, 1023),
            $urandom_range(0, 1023), t, 1'($urandom_range(0, 1))));
        end
      endcase
    end
  endtask

  initial begin
    int t;
    dz_reg = '{200, 520, 562, 885, 120, 476, 522, 880};
    seen_x = '0; seen_y = '0; centred = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed: centre, re-arm, extremes, both modes, wrap, huge elapsed
    pending_words.push_back(make_word(541, 499, 10, 0));
    pending_words.push_back(make_word(1023, 499, 20, 0));
    pending_words.push_back(make_word(1023, 499, 40, 0));
    pending_words.push_back(make_word(0, 1023, 90, 0));
    pending_words.push_back(make_word(0, 0, 65535, 1));
    pending_words.push_back(make_word(1023, 1023, 5, 1));
    pending_words.push_back(make_word(600, 440, 300, 0));
    pending_words.push_back(make_word(600, 440, 301, 1));
    pending_words.push_back(make_word(521, 477, 302, 0));
    pending_words.push_back(make_word(519, 523, 303, 0));
    pending_words.push_back(make_word(100, 900, 20000, 0));
    pending_words.push_back(make_word(541, 0, 20000, 1));
    pending_words.push_back(make_word(541, 499, 0, 1));
    drain();

    // Empty ranges and all-ones registers
    write_reg(REG_X_MIN, 10'd1023); write_reg(REG_X_DLO, 10'd0);
    write_reg(REG_X_DHI, 10'd1023); write_reg(REG_X_MAX, 10'd0);
    write_reg(REG_Y_MIN, 10'd600);  write_reg(REG_Y_DLO, 10'd500);
    write_reg(REG_Y_DHI, 10'd510);  write_reg(REG_Y_MAX, 10'd510);
    t = 1000;
    pending_words.push_back(make_word(0, 505, 900, 0));
    pending_words.push_back(make_word(0, 0, 1000, 0));
    pending_words.push_back(make_word(0, 1023, 1100, 1));
    queue_random(60, t);
    drain();

    // Narrow ranges near the rails
    write_reg(REG_X_MIN, 10'd0);   write_reg(REG_X_DLO, 10'd1);
    write_reg(REG_X_DHI, 10'd1022); write_reg(REG_X_MAX, 10'd1023);
    write_reg(REG_Y_MIN, 10'd0);   write_reg(REG_Y_DLO, 10'd511);
    write_reg(REG_Y_DHI, 10'd512); write_reg(REG_Y_MAX, 10'd1023);
    queue_random(200, t);
    drain();

    // Back to the defaults, then random settings, final part without idling
    dz_reg = '{200, 520, 562, 885, 120, 476, 522, 880};
    for (int i = 0; i < 8; i++) write_reg(3'(i), dz_reg[i]);
    queue_random(150, t);
    drain();
    for (int i = 0; i < 8; i++) write_reg(3'(i), 10'($urandom_range(0, 1023)));
    queue_random(100, t);
    drain();
    calm = 1'b1;
    for (int i = 0; i < 8; i++)
      write_reg(3'(i), (i % 4 < 2) ? 10'($urandom_range(0, 511)) : 10'($urandom_range(512, 1023)));
    queue_random(100, t);
    drain();

    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule
